// ===== rtl/triangle_area_heron_top_assert.svh =====
// Assertion macros used by the checker file of this block.
// Every property is clocked on clk and switched off while arst_n is low.
`ifndef TRIANGLE_AREA_HERON_TOP_ASSERT_SVH
`define TRIANGLE_AREA_HERON_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define HTA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons, delayed by dly
`define HTA_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== rtl/hta_pkg.sv =====
package hta_pkg;

	localparam int COORD_W       = 16;
	localparam int FRAC_BITS_DEF = 4;
	localparam int AREA_W        = 28;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by_coord;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} hta_req_t;

	typedef struct packed {
		logic [AREA_W-1:0] tri_area;
		logic              degenerate;
	} hta_res_t;

	// bits of a side length: root of (dx^2 + dy^2) << (16 - 2*frac)
	function automatic int side_w(input int frac);
		int rad_w;
		rad_w = 2 * COORD_W + 1 + 16 - 2 * frac;
		return (rad_w + 1) >> 1;
	endfunction

	// bits of p1 = f0*f1; also the bits of the final root
	function automatic int prod_w(input int frac);
		return 2 * (side_w(frac) + 2);
	endfunction

	// request accept edge to result accept edge
	function automatic int latency(input int frac);
		return side_w(frac) + prod_w(frac) + 8;
	endfunction

endpackage

// ===== rtl/hta_sqrt_cell.sv =====
// One digit of a restoring square root: takes two radicand bits, yields one root bit.
module hta_sqrt_cell #(
	parameter int ROOT_W = 8
) (
	input  logic                  clk,
	input  logic [2*ROOT_W-1:0]   rad_in,
	input  logic [ROOT_W+1:0]     rem_in,
	input  logic [ROOT_W-1:0]     root_in,
	output logic [2*ROOT_W-1:0]   rad_q,
	output logic [ROOT_W+1:0]     rem_q,
	output logic [ROOT_W-1:0]     root_q
);

	localparam int RW = ROOT_W + 2;

	logic [RW-1:0] shifted;
	logic [RW:0]   trial;
	logic          ge;

	assign shifted = {rem_in[RW-3:0], rad_in[2*ROOT_W-1 -: 2]};
	assign trial   = {1'b0, shifted} - {1'b0, root_in, 2'b01};
	assign ge      = ~trial[RW];

	always_ff @(posedge clk) begin
		rad_q  <= {rad_in[2*ROOT_W-3:0], 2'b00};
		rem_q  <= ge ? trial[RW-1:0] : shifted;
		root_q <= {root_in[ROOT_W-2:0], ge};
	end

endmodule

// ===== rtl/hta_sqrt_chain.sv =====
// Row of ROOT_W root cells, one registered cell per result bit; floor square root.
module hta_sqrt_chain #(
	parameter int ROOT_W = 8
) (
	input  logic                clk,
	input  logic [2*ROOT_W-1:0] rad,
	output logic [ROOT_W-1:0]   root
);

	logic [2*ROOT_W-1:0] rad_w  [ROOT_W+1];
	logic [ROOT_W+1:0]   rem_w  [ROOT_W+1];
	logic [ROOT_W-1:0]   root_w [ROOT_W+1];

	assign rad_w[0]  = rad;
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		hta_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
			.clk     (clk),
			.rad_in  (rad_w[i]),
			.rem_in  (rem_w[i]),
			.root_in (root_w[i]),
			.rad_q   (rad_w[i+1]),
			.rem_q   (rem_w[i+1]),
			.root_q  (root_w[i+1])
		);
	end

	assign root = root_w[ROOT_W];

endmodule

// ===== rtl/triangle_area_heron_top.sv =====
// Triangle area by Heron's formula, fixed point.
// Request: start with req (vertices A, B, C; signed, FRAC_BITS fraction bits).
//   A request is taken at a clock edge where start is high and busy is low.
//   busy is only high in reset and the first cycle after it; otherwise the
//   block takes a new request every cycle.
// Result: done is high for exactly one cycle with res (tri_area, degenerate).
//   There is no back-pressure; the receiver must take the result then.
// The path from accept edge to result edge runs through the two root cell rows:
//   side_w cells for the three side lengths and prod_w cells for the area.
// Throughput: one request per cycle, results in request order.
// Reset: arst_n clears all valid bits and raises busy; payload regs are not reset.
// Pipeline: abs diffs, squares, radicands, side root row, Heron factors
//   (negative factors clamped, degenerate set), two products, four partial
//   products, product sum, area root row, scale and saturate to 28 bits.
module triangle_area_heron_top #(
	parameter int FRAC_BITS = hta_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hta_pkg::hta_req_t req,
	output logic             done,
	output hta_pkg::hta_res_t res
);

	localparam int CW   = hta_pkg::COORD_W;
	localparam int SW   = hta_pkg::side_w(FRAC_BITS);   // side root bits
	localparam int FW   = SW + 2;                       // Heron factor bits
	localparam int PW   = hta_pkg::prod_w(FRAC_BITS);   // f0*f1 bits, area root bits
	localparam int HW   = (PW + 1) / 2;                 // partial product split
	localparam int SQW  = 2 * CW;
	localparam int SUMW = 2 * CW + 1;
	localparam int SH   = 16 - 2 * FRAC_BITS;
	localparam int AS   = 18 - FRAC_BITS;
	localparam int AW   = (PW > hta_pkg::AREA_W) ? PW : hta_pkg::AREA_W;

	function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] q);
		logic signed [CW:0] d;
		d = {p[CW-1], p} - {q[CW-1], q};
		return d[CW] ? CW'(-d) : d[CW-1:0];
	endfunction

	// ---------------- accept
	logic busy_q;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start & ~busy_q;

	// ---------------- valid / degenerate tracking
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [SW-1:0] sv_q;   // alongside side root row
	logic [PW-1:0] av_q;   // alongside area root row
	logic [PW-1:0] ad_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			sv_q   <= '0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			av_q   <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			sv_q   <= {sv_q[SW-2:0], v_s3};
			v_s4   <= sv_q[SW-1];
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			av_q   <= {av_q[PW-2:0], v_s7};
			done_q <= av_q[PW-1];
		end
	end

	// ---------------- s1: absolute differences (a = AB, b = AC, c = BC; x then y)
	logic [CW-1:0] dlt_s1 [6];

	always_ff @(posedge clk) begin
		dlt_s1[0] <= abs_diff(req.ax, req.bx);
		dlt_s1[1] <= abs_diff(req.ay, req.by_coord);
		dlt_s1[2] <= abs_diff(req.ax, req.cx);
		dlt_s1[3] <= abs_diff(req.ay, req.cy);
		dlt_s1[4] <= abs_diff(req.bx, req.cx);
		dlt_s1[5] <= abs_diff(req.by_coord, req.cy);
	end

	// ---------------- s2: squares
	logic [SQW-1:0] sq_s2 [6];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			sq_s2[i] <= dlt_s1[i] * dlt_s1[i];
		end
	end

	// ---------------- s3: side radicands
	logic [2*SW-1:0] rad_s3 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			rad_s3[k] <= (2*SW)'(SUMW'(sq_s2[2*k]) + SUMW'(sq_s2[2*k+1])) << SH;
		end
	end

	// ---------------- side root rows
	logic [SW-1:0] side [3];

	for (genvar k = 0; k < 3; k++) begin : g_side
		hta_sqrt_chain #(.ROOT_W(SW)) u_side (
			.clk  (clk),
			.rad  (rad_s3[k]),
			.root (side[k])
		);
	end

	// ---------------- s4: Heron factors, clamp at zero
	logic signed [FW:0] fs [4];
	logic [FW-1:0]      f_s4 [4];
	logic               dg_s4, dg_s5, dg_s6, dg_s7;

	always_comb begin
		fs[0] =  $signed({3'b000, side[0]}) + $signed({3'b000, side[1]})
			+ $signed({3'b000, side[2]});
		fs[1] = -$signed({3'b000, side[0]}) + $signed({3'b000, side[1]})
			+ $signed({3'b000, side[2]});
		fs[2] =  $signed({3'b000, side[0]}) - $signed({3'b000, side[1]})
			+ $signed({3'b000, side[2]});
		fs[3] =  $signed({3'b000, side[0]}) + $signed({3'b000, side[1]})
			- $signed({3'b000, side[2]});
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			f_s4[i] <= fs[i][FW] ? '0 : fs[i][FW-1:0];
		end
		dg_s4 <= fs[1][FW] | fs[2][FW] | fs[3][FW];
	end

	// ---------------- s5: pair products
	logic [PW-1:0] p1_s5, p2_s5;

	always_ff @(posedge clk) begin
		p1_s5 <= PW'(f_s4[0]) * PW'(f_s4[1]);
		p2_s5 <= PW'(f_s4[2]) * PW'(f_s4[3]);
		dg_s5 <= dg_s4;
	end

	// ---------------- s6: partial products of p1 * p2
	logic [2*HW-1:0] p1x, p2x;
	logic [2*HW-1:0] pp_s6 [4];   // ll, lh, hl, hh

	assign p1x = (2*HW)'(p1_s5);
	assign p2x = (2*HW)'(p2_s5);

	always_ff @(posedge clk) begin
		pp_s6[0] <= p1x[HW-1:0]    * p2x[HW-1:0];
		pp_s6[1] <= p1x[HW-1:0]    * p2x[2*HW-1:HW];
		pp_s6[2] <= p1x[2*HW-1:HW] * p2x[HW-1:0];
		pp_s6[3] <= p1x[2*HW-1:HW] * p2x[2*HW-1:HW];
		dg_s6    <= dg_s5;
	end

	// ---------------- s7: full product (16 * S^2, scaled)
	logic [4*HW-1:0] prod_full;
	logic [2*PW-1:0] prod_s7;

	assign prod_full = {pp_s6[3], pp_s6[0]}
		+ ((4*HW)'({1'b0, pp_s6[1]} + {1'b0, pp_s6[2]}) << HW);

	always_ff @(posedge clk) begin
		prod_s7 <= prod_full[2*PW-1:0];
		dg_s7   <= dg_s6;
	end

	// ---------------- area root row
	logic [PW-1:0] root;

	hta_sqrt_chain #(.ROOT_W(PW)) u_area (
		.clk  (clk),
		.rad  (prod_s7),
		.root (root)
	);

	always_ff @(posedge clk) begin
		ad_q <= {ad_q[PW-2:0], dg_s7};
	end

	// ---------------- output: scale, saturate, register
	logic [AW-1:0]      area_full;
	hta_pkg::hta_res_t  res_q;

	assign area_full = AW'(root >> AS);

	always_ff @(posedge clk) begin
		res_q.tri_area   <= (area_full > AW'(hta_pkg::AREA_MAX)) ? hta_pkg::AREA_MAX
			: area_full[hta_pkg::AREA_W-1:0];
		res_q.degenerate <= ad_q[PW-1];
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/hta_checker.sv =====
module hta_checker #(
	parameter int FRAC_BITS = hta_pkg::FRAC_BITS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input hta_pkg::hta_req_t req,
	input logic              done,
	input hta_pkg::hta_res_t res
);

`include "triangle_area_heron_top_assert.svh"

	localparam int LAT = hta_pkg::latency(FRAC_BITS);

	// every result traces back to an earlier accepted request
	`HTA_ASSERT_IMPL(a_done_has_req, done, $past(start && !busy, LAT), "result without request")
	`HTA_ASSERT_DELAY(a_req_gets_done, start && !busy, LAT, done, "request lost")
	`HTA_ASSERT_IMPL(a_degen_zero, done && res.degenerate, res.tri_area == '0, "degenerate with area")
	// A on B: flat triangle, exact zero, not degenerate
	`HTA_ASSERT_DELAY(a_coincident, start && !busy && req.ax == req.bx && req.ay == req.by_coord, LAT, done && res.tri_area == '0 && !res.degenerate, "coincident vertices")

endmodule

bind triangle_area_heron_top hta_checker #(.FRAC_BITS(FRAC_BITS)) u_hta_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.res    (res)
);
